[hw/rtl/sia_pkg.sv]
package sia_pkg;

  localparam int DATA_W      = 16;
  localparam int WORD_W      = 32;
  localparam int DIV_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int SHIFT_MAX   = 31;
  localparam int JI_SCALE    = 1684;
  localparam int JI_LIMIT    = 1683;
  localparam int JI_FOLD_W   = 11;
  localparam int MS_FACTOR   = 1000;
  localparam int MSPB_MIN    = 2;
  localparam int MSPB_MAX    = 1000;
  localparam int MSPB_BPM_W  = 10;
  localparam int MSPB_T_W    = 25;
  // (a << 20) / 60 is a * 17476 + floor(a * 17480 / 2^16) for a in 2..1000.
  localparam int MSPB_REC_A  = 17476;
  localparam int MSPB_REC_B  = 17480;
  localparam int MSPB_SHIFT  = 11;

  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_SUB     = 5'd1,
    OP_MUL     = 5'd2,
    OP_DIV     = 5'd3,
    OP_MOD     = 5'd4,
    OP_MIN     = 5'd5,
    OP_MAX     = 5'd6,
    OP_LIM     = 5'd7,
    OP_WRAP    = 5'd8,
    OP_QT      = 5'd9,
    OP_AVG     = 5'd10,
    OP_EQ      = 5'd11,
    OP_NE      = 5'd12,
    OP_LT      = 5'd13,
    OP_GT      = 5'd14,
    OP_LTE     = 5'd15,
    OP_GTE     = 5'd16,
    OP_NZ      = 5'd17,
    OP_EZ      = 5'd18,
    OP_RSH     = 5'd19,
    OP_LSH     = 5'd20,
    OP_ABS     = 5'd21,
    OP_AND     = 5'd22,
    OP_OR      = 5'd23,
    OP_JI      = 5'd24,
    OP_RESCALE = 5'd25,
    OP_MSPB    = 5'd26
  } action_t;

  typedef enum logic [2:0] {
    POST_DIV,
    POST_MOD,
    POST_WRAP,
    POST_QT,
    POST_JI,
    POST_SCALE,
    POST_MSPB
  } post_op_t;

  // One classified transaction as it waits between front and back.
  typedef struct packed {
    logic              use_div;
    post_op_t          post;
    logic [DATA_W-1:0] simple;
    logic [WORD_W-1:0] dvd;
    logic [WORD_W-1:0] dvs;
    logic [DATA_W-1:0] aux;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mq_stat_t;

  // Context that travels alongside the divider stages.
  typedef struct packed {
    logic              use_div;
    post_op_t          post;
    logic [DATA_W-1:0] simple;
    logic [DATA_W-1:0] aux;
    logic              qneg;
    logic              rneg;
    logic              dvs_neg;
    logic [WORD_W-1:0] dvs_mag;
  } ctx_t;

endpackage

[hw/rtl/sia_front.sv]
module sia_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [4:0]               action,
  input  logic signed [15:0]       arg_first,
  input  logic signed [15:0]       arg_second,
  input  logic signed [15:0]       arg_third,
  input  logic signed [15:0]       arg_fourth,
  input  logic signed [15:0]       arg_fifth,
  input  sia_pkg::mq_stat_t        mq_stat,
  output logic                     f_valid,
  output sia_pkg::item_t           f_item
);

  logic signed [15:0] a, b, c, d, e;
  logic [4:0]         sc;
  logic signed [31:0] prod_ab;
  logic signed [16:0] d1, d2, den, x, sum_ab;
  logic signed [33:0] p_scale;
  logic signed [15:0] lo, hi;
  logic signed [17:0] n;
  logic [sia_pkg::MSPB_BPM_W-1:0] ac;
  logic [sia_pkg::MSPB_T_W-1:0]   t_hi, t_wide, t;
  logic               accept;
  sia_pkg::item_t     item;

  assign a = arg_first;
  assign b = arg_second;
  assign c = arg_third;
  assign d = arg_fourth;
  assign e = arg_fifth;

  assign prod_ab = a * b;
  assign d1      = $signed({e[15], e}) - $signed({a[15], a});
  assign d2      = $signed({d[15], d}) - $signed({c[15], c});
  assign den     = $signed({b[15], b}) - $signed({a[15], a});
  assign p_scale = d1 * d2;
  assign sum_ab  = $signed({a[15], a}) + $signed({b[15], b});
  assign lo      = (b < c) ? b : c;
  assign hi      = (b < c) ? c : b;
  assign n       = $signed({{2{hi[15]}}, hi}) - $signed({{2{lo[15]}}, lo}) + 18'sd1;
  assign x       = $signed({a[15], a}) - $signed({lo[15], lo});

  always_comb begin
    if (b < 16'sd0) begin
      sc = 5'd0;
    end else if (b > 16'(sia_pkg::SHIFT_MAX)) begin
      sc = 5'(sia_pkg::SHIFT_MAX);
    end else begin
      sc = b[4:0];
    end
    if (a < 16'(sia_pkg::MSPB_MIN)) begin
      ac = sia_pkg::MSPB_BPM_W'(sia_pkg::MSPB_MIN);
    end else if (a > 16'(sia_pkg::MSPB_MAX)) begin
      ac = sia_pkg::MSPB_BPM_W'(sia_pkg::MSPB_MAX);
    end else begin
      ac = a[sia_pkg::MSPB_BPM_W-1:0];
    end
  end

  assign t_hi   = sia_pkg::MSPB_T_W'(ac) * sia_pkg::MSPB_T_W'(sia_pkg::MSPB_REC_A);
  assign t_wide = sia_pkg::MSPB_T_W'(ac) * sia_pkg::MSPB_T_W'(sia_pkg::MSPB_REC_B);
  assign t      = t_hi + sia_pkg::MSPB_T_W'(t_wide[sia_pkg::MSPB_T_W-1:16]);

  always_comb begin
    item         = '0;
    item.post    = sia_pkg::POST_DIV;
    case (action)
      sia_pkg::OP_ADD: item.simple = a + b;
      sia_pkg::OP_SUB: item.simple = a - b;
      sia_pkg::OP_MUL: item.simple = prod_ab[15:0];
      sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
        if (b != 16'sd0) begin
          item.use_div = 1'b1;
          item.post    = (action == sia_pkg::OP_DIV) ? sia_pkg::POST_DIV : sia_pkg::POST_MOD;
          item.dvd     = {{16{a[15]}}, a};
          item.dvs     = {{16{b[15]}}, b};
        end
      end
      sia_pkg::OP_MIN: item.simple = (b > a) ? a : b;
      sia_pkg::OP_MAX: item.simple = (a > b) ? a : b;
      sia_pkg::OP_LIM: item.simple = (a < b) ? b : ((a > c) ? c : a);
      sia_pkg::OP_WRAP: begin
        item.use_div = 1'b1;
        item.post    = sia_pkg::POST_WRAP;
        item.dvd     = {{15{x[16]}}, x};
        item.dvs     = {{14{n[17]}}, n};
        item.aux     = lo;
      end
      sia_pkg::OP_QT: begin
        if (b != 16'sd0) begin
          item.use_div = 1'b1;
          item.post    = sia_pkg::POST_QT;
          item.dvd     = {{16{a[15]}}, a};
          item.dvs     = {{16{b[15]}}, b};
          item.aux     = a;
        end
      end
      sia_pkg::OP_AVG: item.simple = sum_ab[16:1];
      sia_pkg::OP_EQ:  item.simple = {15'd0, a == b};
      sia_pkg::OP_NE:  item.simple = {15'd0, a != b};
      sia_pkg::OP_LT:  item.simple = {15'd0, a < b};
      sia_pkg::OP_GT:  item.simple = {15'd0, a > b};
      sia_pkg::OP_LTE: item.simple = {15'd0, a <= b};
      sia_pkg::OP_GTE: item.simple = {15'd0, a >= b};
      sia_pkg::OP_NZ:  item.simple = {15'd0, a != 16'sd0};
      sia_pkg::OP_EZ:  item.simple = {15'd0, a == 16'sd0};
      sia_pkg::OP_RSH: item.simple = a >>> sc;
      sia_pkg::OP_LSH: item.simple = a << sc;
      sia_pkg::OP_ABS: item.simple = a[15] ? -a : a;
      sia_pkg::OP_AND: item.simple = {15'd0, (a > 16'sd0) && (b > 16'sd0)};
      sia_pkg::OP_OR:  item.simple = {15'd0, (a > 16'sd0) || (b > 16'sd0)};
      sia_pkg::OP_JI: begin
        if (a != 16'sd0 && b != 16'sd0) begin
          item.use_div = 1'b1;
          item.post    = sia_pkg::POST_JI;
          item.dvd     = {{8{a[15]}}, a, 8'd0};
          item.dvs     = {{16{b[15]}}, b};
        end
      end
      sia_pkg::OP_RESCALE: begin
        if (den != 17'sd0) begin
          item.use_div = 1'b1;
          item.post    = sia_pkg::POST_SCALE;
          item.dvd     = p_scale[31:0];
          item.dvs     = {{15{den[16]}}, den};
          item.aux     = c;
        end
      end
      sia_pkg::OP_MSPB: begin
        item.use_div = 1'b1;
        item.post    = sia_pkg::POST_MSPB;
        item.dvd     = 32'h8000_0000;
        item.dvs     = {{(32 - sia_pkg::MSPB_T_W){1'b0}}, t};
      end
      default: item.simple = '0;
    endcase
  end

  assign full   = f_valid && mq_stat.full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (!mq_stat.full) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= item;
    end
  end

endmodule

[hw/rtl/sia_queue.sv]
module sia_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sia_pkg::item_t    push_item,
  input  logic              pop,
  output sia_pkg::item_t    head,
  output sia_pkg::mq_stat_t stat
);

  sia_pkg::item_t                mem [sia_pkg::QUEUE_DEPTH];
  logic [sia_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [sia_pkg::QPTR_W:0]      count;
  logic                          do_push, do_pop;

  assign stat.full  = (count == (sia_pkg::QPTR_W + 1)'(sia_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[hw/rtl/sia_back.sv]
module sia_back (
  input  logic                clk,
  input  logic                rst,
  input  sia_pkg::item_t      mq_item,
  input  sia_pkg::mq_stat_t   mq_stat,
  output logic                mq_pop,
  input  logic                pop,
  output logic                empty,
  output logic signed [15:0]  result
);

  localparam int W = sia_pkg::WORD_W;

  logic                  en;
  logic                  dvd_neg, dvs_neg;
  logic [W-1:0]          dvd_mag, dvs_mag;
  sia_pkg::ctx_t         ctx_in;

  logic [W-1:0]          rem [sia_pkg::DIV_W+1];
  logic [W-1:0]          quo [sia_pkg::DIV_W+1];
  sia_pkg::ctx_t         ctx [sia_pkg::DIV_W+1];
  logic                  vld [sia_pkg::DIV_W+1];

  logic signed [W-1:0]   qa, ra;
  sia_pkg::ctx_t         ctx_a;
  logic                  va;

  logic [W-1:0]          vb;
  sia_pkg::post_op_t     post_b;
  logic                  vbv;
  logic [W-1:0]          val;

  logic signed [W-1:0]   b_full, aux_w, rr, dq;
  logic signed [16:0]    r17, b17;
  logic signed [17:0]    diff18;
  logic [16:0]           abs_r;
  logic [17:0]           abs_d;

  logic [W-1:0]          ji_u;
  logic [4:0]            top_bit, sh;
  logic [sia_pkg::JI_FOLD_W-1:0] fold1;
  logic [15:0]           out_val;
  logic                  out_valid;

  assign en     = !out_valid || pop;
  assign mq_pop = en && !mq_stat.empty;
  assign empty  = !out_valid;

  // Sign handling: the divider works on magnitudes; the bpm constant is unsigned.
  always_comb begin
    dvd_neg        = mq_item.dvd[W-1] && (mq_item.post != sia_pkg::POST_MSPB);
    dvs_neg        = mq_item.dvs[W-1];
    dvd_mag        = dvd_neg ? -mq_item.dvd : mq_item.dvd;
    dvs_mag        = dvs_neg ? -mq_item.dvs : mq_item.dvs;
    ctx_in.use_div = mq_item.use_div;
    ctx_in.post    = mq_item.post;
    ctx_in.simple  = mq_item.simple;
    ctx_in.aux     = mq_item.aux;
    ctx_in.qneg    = dvd_neg ^ dvs_neg;
    ctx_in.rneg    = dvd_neg;
    ctx_in.dvs_neg = dvs_neg;
    ctx_in.dvs_mag = dvs_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= !mq_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      quo[0] <= dvd_mag;
      ctx[0] <= ctx_in;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 0; k < sia_pkg::DIV_W; k++) begin : g_div
    logic [W:0] shifted, trial;

    assign shifted = {rem[k], quo[k][W-1]};
    assign trial   = shifted - {1'b0, ctx[k].dvs_mag};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx[k+1] <= ctx[k];
        if (!trial[W]) begin
          rem[k+1] <= trial[W-1:0];
          quo[k+1] <= {quo[k][W-2:0], 1'b1};
        end else begin
          rem[k+1] <= shifted[W-1:0];
          quo[k+1] <= {quo[k][W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= vld[sia_pkg::DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa    <= ctx[sia_pkg::DIV_W].qneg ? -quo[sia_pkg::DIV_W] : quo[sia_pkg::DIV_W];
      ra    <= ctx[sia_pkg::DIV_W].rneg ? -rem[sia_pkg::DIV_W] : rem[sia_pkg::DIV_W];
      ctx_a <= ctx[sia_pkg::DIV_W];
    end
  end

  always_comb begin
    b_full = ctx_a.dvs_neg ? -ctx_a.dvs_mag : ctx_a.dvs_mag;
    aux_w  = {{(W-16){ctx_a.aux[15]}}, ctx_a.aux};
    rr     = ra[W-1] ? ra + ctx_a.dvs_mag : ra;
    r17    = ra[16:0];
    b17    = b_full[16:0];
    diff18 = $signed({r17[16], r17}) - $signed({b17[16], b17});
    abs_r  = r17[16] ? -r17 : r17;
    abs_d  = diff18[17] ? -diff18 : diff18;
    dq     = aux_w - ra;
    case (ctx_a.post)
      sia_pkg::POST_DIV:   val = qa;
      sia_pkg::POST_MOD:   val = ra;
      sia_pkg::POST_WRAP:  val = aux_w + rr;
      sia_pkg::POST_QT:    val = ({1'b0, abs_r} < abs_d) ? dq : dq + b_full;
      sia_pkg::POST_JI:    val = qa * W'(sia_pkg::JI_SCALE);
      sia_pkg::POST_SCALE: val = qa + aux_w;
      sia_pkg::POST_MSPB:  val = qa * W'(sia_pkg::MS_FACTOR);
      default:             val = '0;
    endcase
    if (!ctx_a.use_div) begin
      val = {{(W-16){ctx_a.simple[15]}}, ctx_a.simple};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbv <= 1'b0;
    end else if (en) begin
      vbv <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vb     <= val;
      post_b <= ctx_a.use_div ? ctx_a.post : sia_pkg::POST_DIV;
    end
  end

  // Halve the ratio until it falls within one octave of the table.
  always_comb begin
    ji_u    = W'($signed(vb) >>> 8);
    top_bit = '0;
    for (int i = 0; i < W; i++) begin
      if (ji_u[i]) begin
        top_bit = 5'(i);
      end
    end
    sh    = top_bit - 5'(sia_pkg::JI_FOLD_W - 1);
    fold1 = sia_pkg::JI_FOLD_W'(ji_u >> sh);
    case (post_b)
      sia_pkg::POST_JI: begin
        if (ji_u <= W'(sia_pkg::JI_LIMIT)) begin
          out_val = ji_u[15:0];
        end else if (fold1 <= sia_pkg::JI_FOLD_W'(sia_pkg::JI_LIMIT)) begin
          out_val = 16'(fold1);
        end else begin
          out_val = 16'(fold1[sia_pkg::JI_FOLD_W-1:1]);
        end
      end
      sia_pkg::POST_MSPB: out_val = vb[sia_pkg::MSPB_SHIFT +: 16];
      default:            out_val = vb[15:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vbv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= out_val;
    end
  end

endmodule

[hw/rtl/script_integer_alu.sv]
// Signed 16-bit ALU for a scripting engine, fed and drained as two queues.
// Input channel: a transaction is taken at a rising edge where push is high
// and full is low; it carries the opcode in action and five signed operands.
// Output channel: while empty is low the oldest result sits on result, and it
// is removed at a rising edge where pop is high.
// Every transaction yields exactly one result, in the order of arrival.
// The path from the accepting edge to the result runs through the classifying
// front register, the four-entry queue between the two halves, the 32-stage
// restoring divider that every transaction passes through and three finishing
// stages after the divider.
// Throughput is one transaction per cycle while pop keeps up.
// When the receiver stalls, the whole back end holds; the front and its queue
// go on accepting until the queue fills, after which full is raised.
// A synchronous reset on rst empties every stage; empty is high and full is
// low in the cycle after reset. No operation keeps any state between
// transactions.
module script_integer_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [4:0]         action,
  input  logic signed [15:0] arg_first,
  input  logic signed [15:0] arg_second,
  input  logic signed [15:0] arg_third,
  input  logic signed [15:0] arg_fourth,
  input  logic signed [15:0] arg_fifth,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] result
);

  // Front register to mid queue.
  logic              f_valid;
  sia_pkg::item_t    f_item;

  // Mid queue to back end.
  sia_pkg::item_t    mq_item;
  sia_pkg::mq_stat_t mq_stat;
  logic              mq_pop;

  // The front classifies each transaction and prepares divider operands.
  sia_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .arg_first  (arg_first),
    .arg_second (arg_second),
    .arg_third  (arg_third),
    .arg_fourth (arg_fourth),
    .arg_fifth  (arg_fifth),
    .mq_stat    (mq_stat),
    .f_valid    (f_valid),
    .f_item     (f_item)
  );

  // The short queue lets the front keep accepting while the back stalls.
  sia_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (mq_pop),
    .head      (mq_item),
    .stat      (mq_stat)
  );

  // The back end runs the divider and finishes each operation.
  sia_back u_back (
    .clk     (clk),
    .rst     (rst),
    .mq_item (mq_item),
    .mq_stat (mq_stat),
    .mq_pop  (mq_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

`ifndef ASSERT_OFF
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("channels not idle after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost while the receiver stalled");

  a_mq_pop_safe: assert property (@(posedge clk) disable iff (rst)
    mq_pop |-> !mq_stat.empty)
    else $error("back end drew from an empty mid queue");

  a_full_needs_item: assert property (@(posedge clk) disable iff (rst)
    full |-> (f_valid && mq_stat.full))
    else $error("full raised without a held transaction");
`endif

endmodule

[tb/sv/script_integer_alu_tb.sv]
`timescale 1ns / 100ps

module script_integer_alu_tb;

  // One operation waiting to be offered to the ALU. When hold_for_drain is
  // set, the driver keeps it back until every outstanding result has come.
  typedef struct {
    logic [4:0]         op;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
    logic signed [15:0] e;
    bit                 hold_for_drain;
  } alu_op_t;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic [4:0]         action = '0;
  logic signed [15:0] arg_first = '0;
  logic signed [15:0] arg_second = '0;
  logic signed [15:0] arg_third = '0;
  logic signed [15:0] arg_fourth = '0;
  logic signed [15:0] arg_fifth = '0;
  logic               full;
  logic               empty;
  logic signed [15:0] result;

  alu_op_t     pending_ops[$];
  logic [15:0] expected_results[$];
  int          cycle_count = 0;
  int          error_count = 0;

  script_integer_alu dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .arg_first  (arg_first),
    .arg_second (arg_second),
    .arg_third  (arg_third),
    .arg_fourth (arg_fourth),
    .arg_fifth  (arg_fifth),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Intermediates wrap at 32 bits, so every step of the arithmetic is folded
  // back into a signed 32-bit value.
  function automatic longint wrap32(longint v);
    int t;
    t = v[31:0];
    return t;
  endfunction

  function automatic longint shift_amount(longint v);
    return (v < 0) ? 0 : ((v > sia_pkg::SHIFT_MAX) ? sia_pkg::SHIFT_MAX : v);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Works out the 16-bit result the ALU should give for one operation.
  function automatic logic [15:0] alu_eval(alu_op_t t);
    longint a, b, c, d, e, r, lo, hi, n, q, p, m1, m2;
    logic [31:0] u;
    logic [31:0] period;
    a = t.a;
    b = t.b;
    c = t.c;
    d = t.d;
    e = t.e;
    r = 0;
    case (t.op)
      sia_pkg::OP_ADD: r = wrap32(a + b);
      sia_pkg::OP_SUB: r = wrap32(a - b);
      sia_pkg::OP_MUL: r = wrap32(a * b);
      sia_pkg::OP_DIV: r = (b != 0) ? wrap32(a / b) : 0;
      sia_pkg::OP_MOD: r = (b != 0) ? wrap32(a % b) : 0;
      sia_pkg::OP_MIN: r = (b > a) ? a : b;
      sia_pkg::OP_MAX: r = (a > b) ? a : b;
      sia_pkg::OP_LIM: r = (a < b) ? b : ((a > c) ? c : a);
      sia_pkg::OP_WRAP: begin
        lo = (b < c) ? b : c;
        hi = (b < c) ? c : b;
        n = hi - lo + 1;
        r = (a - lo) % n;
        if (r < 0) r += n;
        r = lo + r;
      end
      sia_pkg::OP_QT: begin
        // Pick the nearer of the truncated multiple and the one beyond it;
        // a tie goes to the one beyond.
        if (b != 0) begin
          q = wrap32(a / b);
          m1 = wrap32(q * b);
          m2 = wrap32((q + 1) * b);
          r = (magnitude(wrap32(a - m1)) < magnitude(wrap32(a - m2))) ? m1 : m2;
        end
      end
      sia_pkg::OP_AVG: r = wrap32(a + b) >>> 1;
      sia_pkg::OP_EQ:  r = (a == b);
      sia_pkg::OP_NE:  r = (a != b);
      sia_pkg::OP_LT:  r = (a < b);
      sia_pkg::OP_GT:  r = (a > b);
      sia_pkg::OP_LTE: r = (a <= b);
      sia_pkg::OP_GTE: r = (a >= b);
      sia_pkg::OP_NZ:  r = (a != 0);
      sia_pkg::OP_EZ:  r = (a == 0);
      sia_pkg::OP_RSH: r = a >>> shift_amount(b);
      sia_pkg::OP_LSH: r = wrap32(a << shift_amount(b));
      sia_pkg::OP_ABS: r = (a < 0) ? wrap32(-a) : a;
      sia_pkg::OP_AND: r = (a > 0) && (b > 0);
      sia_pkg::OP_OR:  r = (a > 0) || (b > 0);
      sia_pkg::OP_JI: begin
        // Ratio in 8-bit fixed point, scaled, then halved until it folds
        // into the octave.
        if (a != 0 && b != 0) begin
          q = wrap32(wrap32(a * 256) / b);
          p = wrap32(q * sia_pkg::JI_SCALE);
          u = 32'(p >>> 8);
          for (int k = 0; k < 32 && u > sia_pkg::JI_LIMIT; k++) u = u >> 1;
          r = u;
        end
      end
      sia_pkg::OP_RESCALE: begin
        n = wrap32(b - a);
        if (n != 0) begin
          p = wrap32(wrap32(e - a) * wrap32(d - c));
          r = wrap32(wrap32(p / n) + c);
        end
      end
      sia_pkg::OP_MSPB: begin
        if (a < sia_pkg::MSPB_MIN) a = sia_pkg::MSPB_MIN;
        if (a > sia_pkg::MSPB_MAX) a = sia_pkg::MSPB_MAX;
        period = 32'((a << 20) / 60);
        u = (32'h8000_0000 / period) * sia_pkg::MS_FACTOR;
        r = u >> sia_pkg::MSPB_SHIFT;
      end
      default: r = 0;
    endcase
    return r[15:0];
  endfunction

  // No idling on either side in a long stretch in the middle of the run.
  function automatic bit side_idles();
    if (cycle_count >= 800 && cycle_count < 1400) return 1'b0;
    return $urandom_range(99) < 16;
  endfunction

  task automatic queue_op(logic [4:0] op, int a, int b, int c, int d, int e,
                          bit hold = 1'b0);
    alu_op_t t;
    t.op = op;
    t.a = 16'(a);
    t.b = 16'(b);
    t.c = 16'(c);
    t.d = 16'(d);
    t.e = 16'(e);
    t.hold_for_drain = hold;
    pending_ops.push_back(t);
  endtask

  // Operands are drawn from a blend of classes so that small ranges, shift
  // counts near the limits and the extremes all turn up often.
  function automatic int pick_operand();
    int pick;
    pick = $urandom_range(4);
    case (pick)
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(80) - 40;
      2: begin
        case ($urandom_range(4))
          0: return -32768;
          1: return -1;
          2: return 0;
          3: return 1;
          default: return 32767;
        endcase
      end
      3: return $urandom_range(35);
      default: return $urandom_range(1200) - 100;
    endcase
  endfunction

  // Driver: a transaction is taken at an edge where push is high and full is
  // low. The prediction is made from the values that were on the ports at
  // that edge, then the next transaction (or nothing) is put up. An offer
  // that has not been taken yet is never withdrawn.
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(alu_eval(pending_ops.pop_front()));
      end
      if (push && full) begin
        offer = 1'b1;
      end else begin
        offer = pending_ops.size() != 0 && !side_idles() &&
                !(pending_ops[0].hold_for_drain && expected_results.size() != 0);
      end
      push <= offer;
      if (offer) begin
        action     <= pending_ops[0].op;
        arg_first  <= pending_ops[0].a;
        arg_second <= pending_ops[0].b;
        arg_third  <= pending_ops[0].c;
        arg_fourth <= pending_ops[0].d;
        arg_fifth  <= pending_ops[0].e;
      end
    end
  end

  // Monitor: each result taken off the output queue is checked against the
  // oldest prediction still outstanding.
  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result 0x%04h with no transaction outstanding", result);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (result !== want) begin
            $error("result: expected 0x%04h, got 0x%04h", want, result);
            error_count++;
          end
        end
      end
      pop <= !side_idles();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[script_integer_alu] ERROR");
      $finish;
    end
  end

  initial begin
    // Directed transactions: overflow at the extremes, zero divisors,
    // shift counts out of range, the most negative abs, both range orders,
    // a rounding tie and the opcodes that have no operation behind them.
    queue_op(sia_pkg::OP_ADD, 32767, 1, 0, 0, 0);
    queue_op(sia_pkg::OP_SUB, -32768, 1, 0, 0, 0);
    queue_op(sia_pkg::OP_MUL, 32767, 32767, 0, 0, 0);
    queue_op(sia_pkg::OP_DIV, -32768, -1, 0, 0, 0);
    queue_op(sia_pkg::OP_DIV, 5, 0, 0, 0, 0);
    queue_op(sia_pkg::OP_MOD, -7, 2, 0, 0, 0);
    queue_op(sia_pkg::OP_MOD, 3, 0, 0, 0, 0);
    queue_op(sia_pkg::OP_MIN, -32768, 32767, 0, 0, 0);
    queue_op(sia_pkg::OP_MAX, -32768, 32767, 0, 0, 0);
    queue_op(sia_pkg::OP_LIM, -5, 0, 10, 0, 0);
    queue_op(sia_pkg::OP_LIM, 50, 0, 10, 0, 0);
    queue_op(sia_pkg::OP_WRAP, 12, 10, 3, 0, 0);
    queue_op(sia_pkg::OP_WRAP, -32768, -32768, 32767, 0, 0);
    queue_op(sia_pkg::OP_QT, 7, 0, 0, 0, 0);
    queue_op(sia_pkg::OP_QT, 7, 2, 0, 0, 0);
    queue_op(sia_pkg::OP_AVG, -32768, -32768, 0, 0, 0);
    for (int op = sia_pkg::OP_EQ; op <= sia_pkg::OP_EZ; op++) begin
      queue_op(5'(op), 3, 3, 0, 0, 0);
    end
    queue_op(sia_pkg::OP_RSH, -32768, -5, 0, 0, 0);
    queue_op(sia_pkg::OP_RSH, -32768, 40, 0, 0, 0);
    queue_op(sia_pkg::OP_LSH, 1, 15, 0, 0, 0);
    queue_op(sia_pkg::OP_ABS, -32768, 0, 0, 0, 0);
    queue_op(sia_pkg::OP_AND, 1, -1, 0, 0, 0);
    queue_op(sia_pkg::OP_OR, 1, -1, 0, 0, 0);
    queue_op(sia_pkg::OP_JI, 3, 2, 0, 0, 0);
    queue_op(sia_pkg::OP_JI, 0, 5, 0, 0, 0);
    queue_op(sia_pkg::OP_RESCALE, 7, 7, 1, 2, 3);
    queue_op(sia_pkg::OP_RESCALE, -32768, -32767, -32768, 32767, 32767);
    queue_op(sia_pkg::OP_MSPB, 0, 0, 0, 0, 0);
    queue_op(sia_pkg::OP_MSPB, 32767, 0, 0, 0, 0);
    queue_op(5'd27, 1, 1, 1, 1, 1);
    queue_op(5'd31, -1, -1, -1, -1, -1);

    // Random part: every opcode, including the unused ones, with mixed
    // operands. One transaction midway waits for the output to drain.
    for (int i = 0; i < 2000; i++) begin
      queue_op(5'($urandom_range(31)), pick_operand(), pick_operand(), pick_operand(),
               pick_operand(), pick_operand(), i == 1000);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() == 0 && !push);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("[script_integer_alu] OK");
    end else begin
      $display("[script_integer_alu] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sia_pkg.sv
hw/rtl/sia_front.sv
hw/rtl/sia_queue.sv
hw/rtl/sia_back.sv
hw/rtl/script_integer_alu.sv
tb/sv/script_integer_alu_tb.sv
